@@ hw/rtl/tdps_pkg.sv @@
// shared constants and types of the trial division prime search
`timescale 1ns / 1ps

package tdps_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned SqWidth    = ValueWidth + 2;
  localparam int unsigned CntWidth   = $clog2(ValueWidth + 1);

  typedef enum logic {
    CmdTest   = 1'b0,
    CmdSearch = 1'b1
  } tdps_cmd_e;

  typedef struct packed {
    tdps_cmd_e              command;
    logic [ValueWidth-1:0]  value;
  } tdps_req_t;

  typedef struct packed {
    logic                   is_prime;
    logic [ValueWidth-1:0]  largest_prime;
    logic                   found;
  } tdps_rsp_t;

  typedef struct packed {
    logic load;
    logic rem_start;
    logic next_div;
    logic mark_prime;
    logic next_cand;
  } tdps_ctrl_t;

  typedef struct packed {
    logic cand_lt2;
    logic sq_gt_cand;
    logic rem_done;
    logic rem_zero;
    logic search;
  } tdps_stat_t;

endpackage

@@ hw/rtl/trial_division_prime_search.sv @@
// top level of the trial division prime test and downward prime search
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. The result is shown on rsp_o
// for exactly one cycle with done_o high, and the receiver cannot stall it; busy drops in
// that same cycle, so the next request may be issued alongside the result. Each trial
// divisor costs a visit to the check state and one bit-serial remainder pass, so testing n
// tries the divisors from two up to floor(sqrt(n)), fewer when a small factor turns up early.
// A search repeats that test for every candidate from the value down to the nearest prime,
// so its length follows the prime gap below the value. Values below two finish straight
// from the check state without a remainder pass.
module trial_division_prime_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tdps_pkg::tdps_req_t req_i,
  output logic                done_o,
  output tdps_pkg::tdps_rsp_t rsp_o
);
  import tdps_pkg::*;

  tdps_ctrl_t ctrl;
  tdps_stat_t stat;

  tdps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  tdps_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

@@ hw/rtl/tdps_rem.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module tdps_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tdps_pkg::ValueWidth-1:0] dividend_i,
  input  logic [tdps_pkg::ValueWidth-1:0] divisor_i,
  output logic                            done_o,
  output logic                            zero_o
);
  import tdps_pkg::*;

  logic                  run_q, done_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [ValueWidth-1:0] dvd_q, rem_q, dsr_q;
  logic [ValueWidth:0]   shifted, diff;
  logic [ValueWidth-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, dvd_q[ValueWidth-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = diff[ValueWidth-1:0];
    end else begin
      rem_d = shifted[ValueWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntWidth'(ValueWidth);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == CntWidth'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[ValueWidth-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

@@ hw/rtl/tdps_dp.sv @@
// datapath: candidate, divisor and square registers, result registers
`timescale 1ns / 1ps

module tdps_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdps_pkg::tdps_req_t  req_i,
  input  tdps_pkg::tdps_ctrl_t ctrl_i,
  output tdps_pkg::tdps_stat_t stat_o,
  output tdps_pkg::tdps_rsp_t  rsp_o
);
  import tdps_pkg::*;

  tdps_cmd_e             cmd_q;
  logic [ValueWidth-1:0] cand_q, div_q;
  logic [SqWidth-1:0]    sq_q;
  logic                  first_q;
  tdps_rsp_t             rsp_q;
  logic                  rem_done, rem_zero;

  tdps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.rem_start),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= req_i.command;
      cand_q  <= req_i.value;
      div_q   <= ValueWidth'(2);
      sq_q    <= SqWidth'(4);
      first_q <= 1'b1;
      rsp_q   <= '0;
    end else begin
      if (ctrl_i.next_div) begin
        div_q <= div_q + ValueWidth'(1);
        sq_q  <= sq_q + {1'b0, div_q, 1'b0} + SqWidth'(1);
      end
      if (ctrl_i.next_cand) begin
        cand_q  <= cand_q - ValueWidth'(1);
        div_q   <= ValueWidth'(2);
        sq_q    <= SqWidth'(4);
        first_q <= 1'b0;
      end
      if (ctrl_i.mark_prime) begin
        if (first_q) begin
          rsp_q.is_prime <= 1'b1;
        end
        if (cmd_q == CmdSearch) begin
          rsp_q.largest_prime <= cand_q;
          rsp_q.found         <= 1'b1;
        end
      end
    end
  end

  assign stat_o.cand_lt2   = (cand_q < ValueWidth'(2));
  assign stat_o.sq_gt_cand = (sq_q > {2'b00, cand_q});
  assign stat_o.rem_done   = rem_done;
  assign stat_o.rem_zero   = rem_zero;
  assign stat_o.search     = (cmd_q == CmdSearch);
  assign rsp_o             = rsp_q;

endmodule

@@ hw/rtl/tdps_ctrl.sv @@
// controller state machine sequencing divisors and candidates
`timescale 1ns / 1ps

module tdps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tdps_pkg::tdps_stat_t stat_i,
  output tdps_pkg::tdps_ctrl_t ctrl_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import tdps_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StMod
  } state_e;

  state_e state_q;
  logic   busy_q, done_q;

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      StIdle: begin
        ctrl_o.load = start_i;
      end
      StCheck: begin
        if (!stat_i.cand_lt2) begin
          if (stat_i.sq_gt_cand) begin
            ctrl_o.mark_prime = 1'b1;
          end else begin
            ctrl_o.rem_start = 1'b1;
          end
        end
      end
      StMod: begin
        if (stat_i.rem_done) begin
          if (stat_i.rem_zero) begin
            ctrl_o.next_cand = stat_i.search;
          end else begin
            ctrl_o.next_div = 1'b1;
          end
        end
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StCheck;
            busy_q  <= 1'b1;
          end
        end
        StCheck: begin
          if (stat_i.cand_lt2 || stat_i.sq_gt_cand) begin
            state_q <= StIdle;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else begin
            state_q <= StMod;
          end
        end
        StMod: begin
          if (stat_i.rem_done) begin
            if (stat_i.rem_zero && !stat_i.search) begin
              state_q <= StIdle;
              busy_q  <= 1'b0;
              done_q  <= 1'b1;
            end else begin
              state_q <= StCheck;
            end
          end
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/tdps_checker.sv @@
// port-level checks of the prime search handshake and result fields
`timescale 1ns / 1ps

module tdps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input tdps_pkg::tdps_rsp_t rsp_o
);
  import tdps_pkg::*;

  // an accepted transfer keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.found) |-> (rsp_o.largest_prime >= ValueWidth'(2)))
    else $error("found without a prime of two or more");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.found) |-> (rsp_o.largest_prime == '0))
    else $error("largest prime set without found");

endmodule

bind trial_division_prime_search tdps_checker u_tdps_checker (.*);
